// File: hdl/wpi_pkg.sv
// ----------------------------------------------------------------------------
// wpi_pkg
// Shared types and constants for the waypoint path interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package wpi_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = 4;
  localparam int COORD_W    = 16;
  localparam int TIME_W     = 32;
  localparam int ELAPSED_W  = 33;
  localparam int PCOUNT_W   = 5;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = IDX_W + FRAC_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = 5;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [1:0] REG_DURATION = 2'd0;
  localparam logic [1:0] REG_DELAY    = 2'd1;
  localparam logic [1:0] REG_PCOUNT   = 2'd2;
  localparam logic [1:0] REG_ZOFFSET  = 2'd3;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic [TIME_W-1:0]          move_duration;
    logic [TIME_W-1:0]          start_delay;
    logic [PCOUNT_W-1:0]        point_count;
    logic signed [COORD_W-1:0]  z_offset;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_init;
    logic div_step;
    logic mem_rd;
    logic lerp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  tick_pos;
    logic  tick_end;
    logic  out_free;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/wpi_in_if.sv
// ----------------------------------------------------------------------------
// wpi_in_if
// Input item channel: valid/ready handshake with waypoint and tick payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpi_in_if import wpi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [IDX_W-1:0]          point_index;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [TIME_W-1:0]         tick_delta;

  modport source (
    output valid, func, point_index, point_x, point_y, point_z, tick_delta,
    input  ready
  );
  modport sink (
    input  valid, func, point_index, point_x, point_y, point_z, tick_delta,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/wpi_out_if.sv
// ----------------------------------------------------------------------------
// wpi_out_if
// Result channel: valid/ready handshake with position and status payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpi_out_if import wpi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      position_valid;
  logic                      moving;
  logic                      finished;

  modport source (
    output valid, pos_x, pos_y, pos_z, position_valid, moving, finished,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, position_valid, moving, finished,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/wpi_regs.sv
// ----------------------------------------------------------------------------
// wpi_regs
// APB configuration registers: duration, delay, point count, z offset.
// ----------------------------------------------------------------------------
`default_nettype none

module wpi_regs import wpi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_duration <= TIME_W'(1000);
      cfg.start_delay   <= '0;
      cfg.point_count   <= PCOUNT_W'(2);
      cfg.z_offset      <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DURATION: cfg.move_duration <= pwdata;
        REG_DELAY:    cfg.start_delay   <= pwdata;
        REG_PCOUNT:   cfg.point_count   <= pwdata[PCOUNT_W-1:0];
        REG_ZOFFSET:  cfg.z_offset      <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DURATION: prdata = cfg.move_duration;
      REG_DELAY:    prdata = cfg.start_delay;
      REG_PCOUNT:   prdata = DATA_W'(cfg.point_count);
      REG_ZOFFSET:  prdata = DATA_W'(unsigned'(cfg.z_offset));
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/wpi_ctrl.sv
// ----------------------------------------------------------------------------
// wpi_ctrl
// Sequencer: accept, execute, divide, fetch waypoints, interpolate, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module wpi_ctrl import wpi_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_READ,
    S_LERP,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (status.func == FUNC_TICK && status.tick_pos) begin
            state <= status.tick_end ? S_READ : S_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_MUL: begin
          state <= S_DIV;
          cnt   <= '0;
        end
        S_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) state <= S_READ;
        end
        S_READ: state <= S_LERP;
        S_LERP: state <= S_DONE;
        S_DONE: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.div_init = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.mem_rd   = (state == S_READ);
    cmd.lerp     = (state == S_LERP);
    cmd.out_load = (state == S_DONE) && status.out_free;
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> state == S_EXEC)
    else $error("accepted transaction not executed");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < CNT_W'(DIV_STEPS))
    else $error("divider step count overrun");

endmodule

`default_nettype wire

// File: hdl/wpi_dp.sv
// ----------------------------------------------------------------------------
// wpi_dp
// Datapath: waypoint store, elapsed time, restoring divider, interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module wpi_dp import wpi_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cfg_t                      cfg,
  input  wire cmd_t                      cmd,
  output status_t                        status,
  input  wire logic [1:0]                func,
  input  wire logic [IDX_W-1:0]          point_index,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic signed [COORD_W-1:0] point_z,
  input  wire logic [TIME_W-1:0]         tick_delta,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      pos_x,
  output logic signed [COORD_W-1:0]      pos_y,
  output logic signed [COORD_W-1:0]      pos_z,
  output logic                           position_valid,
  output logic                           moving,
  output logic                           finished
);

  localparam int SUM_W  = ELAPSED_W + 1;
  localparam int SCL_W  = TIME_W + IDX_W;
  localparam int PROD_W = 2 * COORD_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  function automatic logic signed [PROD_W-1:0] lerp_mul(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b,
    input logic [FRAC_W-1:0]         f
  );
    logic signed [COORD_W:0] d;
    logic signed [FRAC_W:0]  fs;
    d  = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    fs = {1'b0, f};
    return PROD_W'(d * fs);
  endfunction

  function automatic logic signed [COORD_W-1:0] lerp_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [PROD_W-1:0]  p
  );
    logic signed [COORD_W+1:0] q;
    logic signed [COORD_W+1:0] r;
    q = p[PROD_W-1:FRAC_W];
    r = {{2{a[COORD_W-1]}}, a} + q;
    return r[COORD_W-1:0];
  endfunction

  point_t                    mem [MAX_POINTS];
  point_t                    rd_a;
  point_t                    rd_b;

  func_t                     func_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [COORD_W-1:0] px_q;
  logic signed [COORD_W-1:0] py_q;
  logic signed [COORD_W-1:0] pz_q;
  logic [TIME_W-1:0]         delta_q;

  logic [ELAPSED_W-1:0]      elapsed;
  logic                      moving_flag;
  logic                      pos_ok;
  logic                      end_flag;
  logic [TIME_W-1:0]         actual;
  logic [TIME_W-1:0]         rem;
  logic [QUO_W-1:0]          quo;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;
  logic signed [PROD_W-1:0]  prod_z;

  logic [IDX_W-1:0]          last_idx;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          actual_full;
  logic [ELAPSED_W-1:0]      end_time;
  logic signed [COORD_W:0]   zsum;
  logic signed [COORD_W-1:0] zsat;
  logic [SCL_W-1:0]          scaled;
  logic [TIME_W:0]           trial;
  logic                      trial_ge;
  logic [IDX_W-1:0]          seg;
  logic [IDX_W-1:0]          addr_a;
  logic [IDX_W-1:0]          addr_b;
  logic                      zero_pos;

  always_comb begin
    if (cfg.point_count < PCOUNT_W'(2)) begin
      last_idx = IDX_W'(1);
    end else if (cfg.point_count > PCOUNT_W'(MAX_POINTS)) begin
      last_idx = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_idx = IDX_W'(cfg.point_count - PCOUNT_W'(1));
    end
  end

  assign sum         = SUM_W'(elapsed) + SUM_W'(delta_q);
  assign actual_full = sum - SUM_W'(cfg.start_delay);
  assign end_time    = ELAPSED_W'(cfg.start_delay) + ELAPSED_W'(cfg.move_duration);

  assign zsum = {pz_q[COORD_W-1], pz_q} + {cfg.z_offset[COORD_W-1], cfg.z_offset};
  always_comb begin
    if (zsum[COORD_W] != zsum[COORD_W-1]) begin
      zsat = zsum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      zsat = zsum[COORD_W-1:0];
    end
  end

  assign scaled   = SCL_W'(actual) * SCL_W'(last_idx);
  assign trial    = {rem, quo[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, cfg.move_duration};
  assign seg      = quo[QUO_W-1:FRAC_W];
  assign addr_a   = end_flag ? last_idx : seg;
  assign addr_b   = seg + IDX_W'(1);

  assign status.func     = func_q;
  assign status.tick_pos = sum >= SUM_W'(cfg.start_delay);
  assign status.tick_end = actual_full >= SUM_W'(cfg.move_duration);
  assign status.out_free = !out_valid || out_ready;

  // input capture, divider and interpolation registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q  <= func_t'(func);
      idx_q   <= point_index;
      px_q    <= point_x;
      py_q    <= point_y;
      pz_q    <= point_z;
      delta_q <= tick_delta;
    end
    if (cmd.exec) begin
      end_flag <= status.tick_end;
      actual   <= actual_full[TIME_W-1:0];
    end
    if (cmd.div_init) begin
      rem <= scaled[SCL_W-1:IDX_W];
      quo <= {scaled[IDX_W-1:0], {FRAC_W{1'b0}}};
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? TIME_W'(trial - {1'b0, cfg.move_duration}) : trial[TIME_W-1:0];
      quo <= {quo[QUO_W-2:0], trial_ge};
    end
    if (cmd.lerp) begin
      prod_x <= lerp_mul(rd_a.x, rd_b.x, quo[FRAC_W-1:0]);
      prod_y <= lerp_mul(rd_a.y, rd_b.y, quo[FRAC_W-1:0]);
      prod_z <= lerp_mul(rd_a.z, rd_b.z, quo[FRAC_W-1:0]);
    end
  end

  // waypoint store
  always_ff @(posedge clk) begin
    if (cmd.exec && func_q == FUNC_LOAD) begin
      mem[idx_q] <= '{x: px_q, y: py_q, z: zsat};
    end
    if (cmd.mem_rd) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed     <= '0;
      moving_flag <= 1'b0;
      pos_ok      <= 1'b0;
    end else if (cmd.exec) begin
      pos_ok <= 1'b0;
      case (func_q)
        FUNC_START: begin
          elapsed     <= '0;
          moving_flag <= 1'b1;
        end
        FUNC_TICK: begin
          if (status.tick_pos) begin
            pos_ok <= 1'b1;
            if (status.tick_end) begin
              elapsed     <= end_time;
              moving_flag <= 1'b0;
            end else begin
              elapsed <= sum[ELAPSED_W-1:0];
            end
          end else begin
            elapsed <= sum[ELAPSED_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign zero_pos = !pos_ok;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (zero_pos) begin
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
      end else if (end_flag) begin
        pos_x <= rd_a.x;
        pos_y <= rd_a.y;
        pos_z <= rd_a.z;
      end else begin
        pos_x <= lerp_add(rd_a.x, prod_x);
        pos_y <= lerp_add(rd_a.y, prod_y);
        pos_z <= lerp_add(rd_a.z, prod_z);
      end
      position_valid <= pos_ok;
      moving         <= moving_flag;
      finished       <= elapsed >= end_time;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < cfg.move_duration)
    else $error("divider remainder not below divisor");

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_rd && !end_flag) |-> seg < last_idx)
    else $error("segment index past last segment");

endmodule

`default_nettype wire

// File: hdl/waypoint_path_interpolator_top.sv
// ----------------------------------------------------------------------------
// waypoint_path_interpolator_top
// Piecewise linear 3-D path interpolation over a loaded waypoint table.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A load, a start, an unused code or a tick
// before the start delay has passed is executed and emitted; a tick that
// reaches the end of the path also reads the last waypoint; a tick that
// interpolates first runs the 20-step restoring divider that finds the
// segment and the Q0.16 fraction in one pass. The result register lets a
// new item be accepted while the previous result waits to be taken. The
// waypoint store has no reset: read only slots that have been loaded.
`default_nettype none

module waypoint_path_interpolator_top import wpi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  wpi_in_if.sink                 items,
  wpi_out_if.source              results
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  wpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wpi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .func           (items.func),
    .point_index    (items.point_index),
    .point_x        (items.point_x),
    .point_y        (items.point_y),
    .point_z        (items.point_z),
    .tick_delta     (items.tick_delta),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .pos_x          (results.pos_x),
    .pos_y          (results.pos_y),
    .pos_z          (results.pos_z),
    .position_valid (results.position_valid),
    .moving         (results.moving),
    .finished       (results.finished)
  );

endmodule

`default_nettype wire

// File: tb/tb_waypoint_path_interpolator_top.sv
// ----------------------------------------------------------------------------
// tb_waypoint_path_interpolator_top
// Self-checking bench for the waypoint path interpolator: loads the waypoint
// table, runs start and tick sequences over many register settings, predicts
// every position in the bench and compares each result transaction with it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_waypoint_path_interpolator_top;
  import wpi_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      pos_valid;
    logic                      moving;
    logic                      finished;
  } position_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  wpi_in_if  items_if ();
  wpi_out_if results_if ();

  waypoint_path_interpolator_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .items   (items_if),
    .results (results_if)
  );

  // predictor state
  logic signed [COORD_W-1:0] wp_x [MAX_POINTS];
  logic signed [COORD_W-1:0] wp_y [MAX_POINTS];
  logic signed [COORD_W-1:0] wp_z [MAX_POINTS];
  logic [63:0]               elapsed_ticks = '0;
  logic                      moving_now = 1'b0;
  logic [TIME_W-1:0]         cfg_duration = 32'd1000;
  logic [TIME_W-1:0]         cfg_delay = '0;
  logic [PCOUNT_W-1:0]       cfg_pcount = 5'd2;
  logic signed [COORD_W-1:0] cfg_zoff = '0;

  position_t pending_positions[$];
  logic      last_finished = 1'b0;
  bit        steady_flow = 1'b0;
  int        error_count = 0;
  int        cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] blend_coord(
      input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b,
      input logic [FRAC_W-1:0] frac);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'({1'b0, frac});
    return COORD_W'(longint'(a) + (prod >>> 16));
  endfunction

  function automatic position_t predict_position(
      input func_t f, input logic [IDX_W-1:0] idx,
      input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
      input logic signed [COORD_W-1:0] pz, input logic [TIME_W-1:0] delta);
    position_t   r;
    logic [63:0] actual, scaled, seg, rem, frac;
    int          zs, n, s;
    r = '0;
    case (f)
      FUNC_LOAD: begin
        zs = int'(pz) + int'(cfg_zoff);
        if (zs > 32767) zs = 32767;
        else if (zs < -32768) zs = -32768;
        wp_x[idx] = px;
        wp_y[idx] = py;
        wp_z[idx] = COORD_W'(zs);
      end
      FUNC_START: begin
        elapsed_ticks = '0;
        moving_now = 1'b1;
      end
      FUNC_TICK: begin
        elapsed_ticks = elapsed_ticks + 64'(delta);
        if (elapsed_ticks >= 64'(cfg_delay)) begin
          actual = elapsed_ticks - 64'(cfg_delay);
          n = int'(cfg_pcount);
          if (n < 2) n = 2;
          if (n > MAX_POINTS) n = MAX_POINTS;
          r.pos_valid = 1'b1;
          if (actual >= 64'(cfg_duration)) begin
            elapsed_ticks = 64'(cfg_delay) + 64'(cfg_duration);
            moving_now = 1'b0;
            r.x = wp_x[n-1];
            r.y = wp_y[n-1];
            r.z = wp_z[n-1];
          end else begin
            scaled = actual * 64'(n - 1);
            seg = scaled / 64'(cfg_duration);
            rem = scaled - seg * 64'(cfg_duration);
            frac = (rem << 16) / 64'(cfg_duration);
            s = (seg > 64'(n - 2)) ? n - 2 : int'(seg);
            r.x = blend_coord(wp_x[s], wp_x[s+1], frac[FRAC_W-1:0]);
            r.y = blend_coord(wp_y[s], wp_y[s+1], frac[FRAC_W-1:0]);
            r.z = blend_coord(wp_z[s], wp_z[s+1], frac[FRAC_W-1:0]);
          end
        end
      end
      default: begin
      end
    endcase
    r.moving = moving_now;
    r.finished = elapsed_ticks >= 64'(cfg_delay) + 64'(cfg_duration);
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // result side: random stall bursts unless the flow is steady
  initial begin : result_stall
    int n;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!steady_flow && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        results_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      results_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    position_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_positions.size() == 0) begin
        $error("result transaction with no expected position");
        error_count++;
      end else begin
        want = pending_positions.pop_front();
        if (results_if.pos_x !== want.x) begin
          $error("pos_x mismatch: expected %0d, got %0d", want.x, results_if.pos_x);
          error_count++;
        end
        if (results_if.pos_y !== want.y) begin
          $error("pos_y mismatch: expected %0d, got %0d", want.y, results_if.pos_y);
          error_count++;
        end
        if (results_if.pos_z !== want.z) begin
          $error("pos_z mismatch: expected %0d, got %0d", want.z, results_if.pos_z);
          error_count++;
        end
        if (results_if.position_valid !== want.pos_valid) begin
          $error("position_valid mismatch: expected %0b, got %0b", want.pos_valid,
                 results_if.position_valid);
          error_count++;
        end
        if (results_if.moving !== want.moving) begin
          $error("moving mismatch: expected %0b, got %0b", want.moving, results_if.moving);
          error_count++;
        end
        if (results_if.finished !== want.finished) begin
          $error("finished mismatch: expected %0b, got %0b", want.finished,
                 results_if.finished);
          error_count++;
        end
      end
    end
  end

  task automatic send_command(input func_t f, input logic [IDX_W-1:0] idx,
      input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
      input logic signed [COORD_W-1:0] pz, input logic [TIME_W-1:0] delta);
    position_t p;
    int        gap;
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p = predict_position(f, idx, px, py, pz, delta);
    last_finished = p.finished;
    pending_positions.insert(pending_positions.size(), p);
    items_if.valid       <= 1'b1;
    items_if.func        <= f;
    items_if.point_index <= idx;
    items_if.point_x     <= px;
    items_if.point_y     <= py;
    items_if.point_z     <= pz;
    items_if.tick_delta  <= delta;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
  endtask

  task automatic send_load(input logic [IDX_W-1:0] idx, input logic signed [COORD_W-1:0] px,
      input logic signed [COORD_W-1:0] py, input logic signed [COORD_W-1:0] pz);
    send_command(FUNC_LOAD, idx, px, py, pz, $urandom);
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] delta);
    send_command(FUNC_TICK, IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
                 delta);
  endtask

  task automatic send_start();
    send_command(FUNC_START, IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
                 $urandom);
  endtask

  task automatic wait_for_positions();
    items_if.valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] reg_id, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_id, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (reg_id)
      REG_DURATION: cfg_duration = value;
      REG_DELAY:    cfg_delay = value;
      REG_PCOUNT:   cfg_pcount = value[PCOUNT_W-1:0];
      REG_ZOFFSET:  cfg_zoff = value[COORD_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic pick_settings();
    logic [31:0] dur, dly, pc, zo;
    case ($urandom_range(0, 7))
      0: dur = 32'd0;
      1: dur = 32'd1;
      2: dur = 32'hFFFF_FFFF;
      3: dur = $urandom;
      4, 5: dur = $urandom_range(2, 200);
      default: dur = $urandom_range(200, 100000);
    endcase
    case ($urandom_range(0, 5))
      0, 1: dly = 32'd0;
      2: dly = 32'hFFFF_FFFF;
      3: dly = $urandom;
      4: dly = $urandom_range(1, 50);
      default: dly = $urandom_range(1, 5000);
    endcase
    pc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
    if ($urandom_range(0, 3) == 0) pc[31:5] = 27'($urandom);
    case ($urandom_range(0, 4))
      0: zo = 32'h0000_7FFF;
      1: zo = 32'h0000_8000;
      2: zo = 32'd0;
      default: zo = {16'd0, 16'($urandom)};
    endcase
    if ($urandom_range(0, 3) == 0) zo[31:16] = 16'($urandom);
    write_register(REG_DURATION, dur);
    write_register(REG_DELAY, dly);
    write_register(REG_PCOUNT, pc);
    write_register(REG_ZOFFSET, zo);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_command(FUNC_NONE, IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
                      $urandom);
      1: send_load(IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord());
      2: send_tick($urandom);
      3: send_tick(32'hFFFF_FFFF);
      default: send_start();
    endcase
  endtask

  // start/tick sequences that walk the path with random loads and noise mixed in
  task automatic run_moves(input int budget);
    int          sent, ticks, k, extra;
    logic [63:0] step, hi;
    sent = 0;
    while (sent < budget) begin
      repeat ($urandom_range(0, 3)) begin
        send_load(IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord());
        sent++;
      end
      send_start();
      sent++;
      k = $urandom_range(3, 40);
      step = (64'(cfg_delay) + 64'(cfg_duration)) / 64'(k);
      if (step == 0) step = 1;
      hi = step * 2;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      ticks = 0;
      while (ticks < 80 && !last_finished) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        else send_tick($urandom_range(0, hi[31:0]));
        ticks++;
        sent++;
      end
      extra = $urandom_range(0, 2);
      repeat (extra) begin
        send_tick($urandom_range(0, hi[31:0]));
        sent++;
      end
    end
  endtask

  task automatic test_directed_cases();
    write_register(REG_PCOUNT, 32'd16);
    write_register(REG_ZOFFSET, 32'h0000_7FFF);
    send_load(4'd0, 16'h8000, 16'h7FFF, 16'h0000);
    send_load(4'd1, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_load(4'd2, 16'h0000, 16'h0000, 16'h8000);
    send_load(4'd3, 16'hFFFF, 16'h0001, 16'd100);
    for (int i = 4; i < 8; i++) send_load(IDX_W'(i), rand_coord(), rand_coord(), rand_coord());
    wait_for_positions();
    write_register(REG_ZOFFSET, 32'h0000_8000);
    send_load(4'd8, 16'h7FFF, 16'h8000, 16'h8000);
    send_load(4'd9, 16'h5555, 16'hAAAA, 16'hFFFF);
    for (int i = 10; i < 15; i++) send_load(IDX_W'(i), rand_coord(), rand_coord(), rand_coord());
    send_load(4'd15, 16'h8000, 16'h7FFF, 16'h7FFF);
    // tick with no start, then a normal move
    send_tick(32'd0);
    send_start();
    send_tick(32'd500);
    send_command(FUNC_NONE, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd1);
    wait_for_positions();
    // zero duration with a delay
    write_register(REG_DURATION, 32'd0);
    write_register(REG_DELAY, 32'd5);
    send_start();
    send_tick(32'd2);
    send_tick(32'd3);
    wait_for_positions();
    write_register(REG_DURATION, 32'hFFFF_FFFF);
    write_register(REG_DELAY, 32'hFFFF_FFFF);
    send_start();
    repeat (3) send_tick(32'hFFFF_FFFF);
  endtask

  task automatic test_random_paths();
    for (int phase = 0; phase < 16; phase++) begin
      wait_for_positions();
      steady_flow = (phase % 4 == 3);
      pick_settings();
      run_moves(120);
    end
  endtask

  task automatic test_steady_stream();
    steady_flow = 1'b1;
    wait_for_positions();
    write_register(REG_DURATION, $urandom_range(50, 5000));
    write_register(REG_DELAY, $urandom_range(0, 100));
    write_register(REG_PCOUNT, 32'd16);
    write_register(REG_ZOFFSET, {16'd0, 16'($urandom)});
    run_moves(150);
  endtask

  initial begin
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    items_if.valid       <= 1'b0;
    items_if.func        <= FUNC_LOAD;
    items_if.point_index <= '0;
    items_if.point_x     <= '0;
    items_if.point_y     <= '0;
    items_if.point_z     <= '0;
    items_if.tick_delta  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_paths();
    test_steady_stream();
    wait_for_positions();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
